@@ hw/rtl/fpa_pkg.sv @@
`default_nettype none
package fpa_pkg;

	localparam int FRAC_BITS = 8;
	localparam int DIV_STEPS = 34;
	localparam int DIV_EXT_W = 66;

	localparam logic [3:0] OP_ADD      = 4'd0;
	localparam logic [3:0] OP_SUB      = 4'd1;
	localparam logic [3:0] OP_MUL      = 4'd2;
	localparam logic [3:0] OP_DIV      = 4'd3;
	localparam logic [3:0] OP_LT       = 4'd4;
	localparam logic [3:0] OP_GT       = 4'd5;
	localparam logic [3:0] OP_LE       = 4'd6;
	localparam logic [3:0] OP_GE       = 4'd7;
	localparam logic [3:0] OP_EQ       = 4'd8;
	localparam logic [3:0] OP_NE       = 4'd9;
	localparam logic [3:0] OP_INC      = 4'd10;
	localparam logic [3:0] OP_DEC      = 4'd11;
	localparam logic [3:0] OP_MIN      = 4'd12;
	localparam logic [3:0] OP_MAX      = 4'd13;
	localparam logic [3:0] OP_FROM_INT = 4'd14;
	localparam logic [3:0] OP_TO_INT   = 4'd15;

	localparam logic [1:0] STAT_OK   = 2'd0;
	localparam logic [1:0] STAT_SAT  = 2'd1;
	localparam logic [1:0] STAT_DIV0 = 2'd2;

	localparam logic [31:0] S32_MAX = 32'h7fff_ffff;
	localparam logic [31:0] S32_MIN = 32'h8000_0000;

	typedef struct packed {
		logic [31:0] res;
		logic        cmp;
		logic [1:0]  status;
		logic        is_div;
		logic        div_sat;
		logic        div_neg;
	} fpa_side_t;

	typedef struct packed {
		logic [31:0] rem;
		logic [DIV_STEPS-1:0] low;
		logic [DIV_STEPS-1:0] quo;
		logic [31:0] den;
	} fpa_div_t;

	// clamp a 33-bit signed sum into 32 bits, msb of result is the overflow flag
	function automatic logic [32:0] sat33(input logic [32:0] v);
		logic [32:0] r;
		begin
			if (v[32] != v[31]) begin
				r = {1'b1, (v[32] ? S32_MIN : S32_MAX)};
			end else begin
				r = {1'b0, v[31:0]};
			end
			return r;
		end
	endfunction

endpackage
`default_nettype wire

@@ hw/rtl/fpa_req_if.sv @@
`default_nettype none
interface fpa_req_if;
	logic               valid;
	logic               ready;
	logic [3:0]         req_type;
	logic signed [31:0] operand_a;
	logic signed [31:0] operand_b;

	modport source(output valid, req_type, operand_a, operand_b, input ready);
	modport sink(input valid, req_type, operand_a, operand_b, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/fpa_rsp_if.sv @@
`default_nettype none
interface fpa_rsp_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] result_value;
	logic               compare_true;
	logic [1:0]         status;

	modport source(output valid, result_value, compare_true, status, input ready);
	modport sink(input valid, result_value, compare_true, status, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/fpa_front.sv @@
`default_nettype none
module fpa_front (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              en,
	input  wire logic              in_valid,
	input  wire logic [3:0]        op,
	input  wire logic [31:0]       a,
	input  wire logic [31:0]       b,
	output logic                   valid_s3,
	output fpa_pkg::fpa_side_t     side_s3,
	output fpa_pkg::fpa_div_t      div_s3
);

	localparam int DIV_EXT_W_L = fpa_pkg::DIV_EXT_W;

	logic        valid_s1;
	logic [3:0]  op_s1;
	logic [31:0] a_s1;
	logic [31:0] b_s1;

	logic               valid_s2;
	fpa_pkg::fpa_side_t side_s2;
	logic               is_mul_s2;
	logic [63:0]        prod_s2;
	logic [31:0]        na_s2;
	logic [31:0]        nb_s2;

	fpa_pkg::fpa_side_t side_c2;
	logic [32:0] sum_c, diff_c, inc_c, dec_c;
	logic [32:0] sat_sum, sat_diff, sat_inc, sat_dec;
	logic [63:0] fi_c;
	logic        fi_ovf;
	logic        lt_c, eq_c;

	fpa_pkg::fpa_side_t side_c3;
	fpa_pkg::fpa_div_t  div_c3;
	logic [63:0] mag_c;
	logic [63:0] rnd_c;
	logic [DIV_EXT_W_L-1:0] dext_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	// stage 1: input register
	always_ff @(posedge clk) begin
		if (en) begin
			op_s1 <= op;
			a_s1  <= a;
			b_s1  <= b;
		end
	end

	// stage 2: simple ops, multiply, divide magnitudes
	always_comb begin
		sum_c    = {a_s1[31], a_s1} + {b_s1[31], b_s1};
		diff_c   = {a_s1[31], a_s1} - {b_s1[31], b_s1};
		inc_c    = {a_s1[31], a_s1} + 33'd1;
		dec_c    = {a_s1[31], a_s1} - 33'd1;
		sat_sum  = fpa_pkg::sat33(sum_c);
		sat_diff = fpa_pkg::sat33(diff_c);
		sat_inc  = fpa_pkg::sat33(inc_c);
		sat_dec  = fpa_pkg::sat33(dec_c);
		fi_c     = {{32{a_s1[31]}}, a_s1} << fpa_pkg::FRAC_BITS;
		fi_ovf   = fi_c[63:31] != {33{fi_c[63]}};
		lt_c     = $signed(a_s1) < $signed(b_s1);
		eq_c     = a_s1 == b_s1;

		side_c2 = '0;
		case (op_s1)
			fpa_pkg::OP_ADD: begin
				side_c2.res    = sat_sum[31:0];
				side_c2.status = sat_sum[32] ? fpa_pkg::STAT_SAT : fpa_pkg::STAT_OK;
			end
			fpa_pkg::OP_SUB: begin
				side_c2.res    = sat_diff[31:0];
				side_c2.status = sat_diff[32] ? fpa_pkg::STAT_SAT : fpa_pkg::STAT_OK;
			end
			fpa_pkg::OP_MUL: begin
				side_c2.res = '0;
			end
			fpa_pkg::OP_DIV: begin
				if (b_s1 == '0) begin
					side_c2.status = fpa_pkg::STAT_DIV0;
				end else begin
					side_c2.is_div  = 1'b1;
					side_c2.div_neg = a_s1[31] ^ b_s1[31];
				end
			end
			fpa_pkg::OP_LT: side_c2.cmp = lt_c;
			fpa_pkg::OP_GT: side_c2.cmp = !lt_c && !eq_c;
			fpa_pkg::OP_LE: side_c2.cmp = lt_c || eq_c;
			fpa_pkg::OP_GE: side_c2.cmp = !lt_c;
			fpa_pkg::OP_EQ: side_c2.cmp = eq_c;
			fpa_pkg::OP_NE: side_c2.cmp = !eq_c;
			fpa_pkg::OP_INC: begin
				side_c2.res    = sat_inc[31:0];
				side_c2.status = sat_inc[32] ? fpa_pkg::STAT_SAT : fpa_pkg::STAT_OK;
			end
			fpa_pkg::OP_DEC: begin
				side_c2.res    = sat_dec[31:0];
				side_c2.status = sat_dec[32] ? fpa_pkg::STAT_SAT : fpa_pkg::STAT_OK;
			end
			fpa_pkg::OP_MIN: side_c2.res = lt_c ? a_s1 : b_s1;
			fpa_pkg::OP_MAX: side_c2.res = lt_c ? b_s1 : a_s1;
			fpa_pkg::OP_FROM_INT: begin
				if (fi_ovf) begin
					side_c2.res    = a_s1[31] ? fpa_pkg::S32_MIN : fpa_pkg::S32_MAX;
					side_c2.status = fpa_pkg::STAT_SAT;
				end else begin
					side_c2.res = fi_c[31:0];
				end
			end
			fpa_pkg::OP_TO_INT: side_c2.res = 32'($signed(a_s1) >>> fpa_pkg::FRAC_BITS);
			default: side_c2 = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s2   <= side_c2;
			is_mul_s2 <= op_s1 == fpa_pkg::OP_MUL;
			prod_s2   <= 64'($signed(a_s1) * $signed(b_s1));
			na_s2     <= a_s1[31] ? 32'(-a_s1) : a_s1;
			nb_s2     <= b_s1[31] ? 32'(-b_s1) : b_s1;
		end
	end

	// stage 3: multiply rounding and divider setup
	always_comb begin
		mag_c   = prod_s2[63] ? 64'(-prod_s2) : prod_s2;
		rnd_c   = (mag_c + (64'd1 << (fpa_pkg::FRAC_BITS - 1))) >> fpa_pkg::FRAC_BITS;
		side_c3 = side_s2;
		if (is_mul_s2) begin
			if (prod_s2[63]) begin
				if (rnd_c > 64'h8000_0000) begin
					side_c3.res    = fpa_pkg::S32_MIN;
					side_c3.status = fpa_pkg::STAT_SAT;
				end else begin
					side_c3.res = 32'(-rnd_c);
				end
			end else begin
				if (rnd_c > 64'h7fff_ffff) begin
					side_c3.res    = fpa_pkg::S32_MAX;
					side_c3.status = fpa_pkg::STAT_SAT;
				end else begin
					side_c3.res = rnd_c[31:0];
				end
			end
		end
		dext_c  = DIV_EXT_W_L'(na_s2) << (fpa_pkg::FRAC_BITS + 1);
		div_c3.rem = dext_c[DIV_EXT_W_L-1 -: 32];
		div_c3.low = dext_c[fpa_pkg::DIV_STEPS-1:0];
		div_c3.quo = '0;
		div_c3.den = nb_s2;
		side_c3.div_sat = dext_c[DIV_EXT_W_L-1 -: 32] >= nb_s2;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s3 <= side_c3;
			div_s3  <= div_c3;
		end
	end

endmodule
`default_nettype wire

@@ hw/rtl/fpa_div_pipe.sv @@
`default_nettype none
module fpa_div_pipe (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               en,
	input  wire logic               in_valid,
	input  fpa_pkg::fpa_side_t      in_side,
	input  fpa_pkg::fpa_div_t       in_div,
	output logic                    out_valid,
	output fpa_pkg::fpa_side_t      out_side,
	output fpa_pkg::fpa_div_t       out_div
);

	logic               valid_s [fpa_pkg::DIV_STEPS];
	fpa_pkg::fpa_side_t side_s  [fpa_pkg::DIV_STEPS];
	fpa_pkg::fpa_div_t  div_s   [fpa_pkg::DIV_STEPS];

	// one quotient bit per stage, restoring
	for (genvar k = 0; k < fpa_pkg::DIV_STEPS; k++) begin : g_step
		logic               v_in;
		fpa_pkg::fpa_side_t s_in;
		fpa_pkg::fpa_div_t  d_in;
		fpa_pkg::fpa_div_t  d_nx;
		logic [32:0]        trial;
		logic               take;

		if (k == 0) begin : g_first
			assign v_in = in_valid;
			assign s_in = in_side;
			assign d_in = in_div;
		end else begin : g_next
			assign v_in = valid_s[k-1];
			assign s_in = side_s[k-1];
			assign d_in = div_s[k-1];
		end

		always_comb begin
			trial    = {d_in.rem, d_in.low[fpa_pkg::DIV_STEPS-1]};
			take     = trial >= {1'b0, d_in.den};
			d_nx.rem = take ? 32'(trial - {1'b0, d_in.den}) : trial[31:0];
			d_nx.low = {d_in.low[fpa_pkg::DIV_STEPS-2:0], 1'b0};
			d_nx.quo = {d_in.quo[fpa_pkg::DIV_STEPS-2:0], take};
			d_nx.den = d_in.den;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[k] <= 1'b0;
			end else if (en) begin
				valid_s[k] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				side_s[k] <= s_in;
				div_s[k]  <= d_nx;
			end
		end
	end

	assign out_valid = valid_s[fpa_pkg::DIV_STEPS-1];
	assign out_side  = side_s[fpa_pkg::DIV_STEPS-1];
	assign out_div   = div_s[fpa_pkg::DIV_STEPS-1];

endmodule
`default_nettype wire

@@ hw/rtl/fpa_back.sv @@
`default_nettype none
module fpa_back (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               en,
	input  wire logic               in_valid,
	input  fpa_pkg::fpa_side_t      in_side,
	input  fpa_pkg::fpa_div_t       in_div,
	output logic                    valid_q,
	output logic [31:0]             res_q,
	output logic                    cmp_q,
	output logic [1:0]              status_q
);

	logic [fpa_pkg::DIV_STEPS:0]   q_ext;
	logic [fpa_pkg::DIV_STEPS-1:0] q_c;
	logic [31:0]                   res_c;
	logic [1:0]                    status_c;

	// round half away from zero on the doubled quotient
	always_comb begin
		q_ext    = {1'b0, in_div.quo} + 1'b1;
		q_c      = q_ext[fpa_pkg::DIV_STEPS:1];
		res_c    = in_side.res;
		status_c = in_side.status;
		if (in_side.is_div) begin
			if (in_side.div_neg) begin
				if (in_side.div_sat || q_c > 34'h0_8000_0000) begin
					res_c    = fpa_pkg::S32_MIN;
					status_c = fpa_pkg::STAT_SAT;
				end else begin
					res_c = 32'(-q_c);
				end
			end else begin
				if (in_side.div_sat || q_c > 34'h0_7fff_ffff) begin
					res_c    = fpa_pkg::S32_MAX;
					status_c = fpa_pkg::STAT_SAT;
				end else begin
					res_c = q_c[31:0];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_q    <= res_c;
			cmp_q    <= in_side.cmp;
			status_q <= status_c;
		end
	end

endmodule
`default_nettype wire

@@ hw/rtl/fixed_point_alu.sv @@
// every opcode takes the same path: the front stages, the divider stages, then the response register
// throughput: one request beat per cycle while the pipe is not stalled; the 34-stage divider sets the depth
// the whole pipe advances whenever the response register is empty or taken
// reset: arst_n clears all valid bits at once; data registers are not reset
`default_nettype none
module fixed_point_alu (
	input  wire logic clk,
	input  wire logic arst_n,
	fpa_req_if.sink   req,
	fpa_rsp_if.source rsp
);

	logic               en;
	logic               valid_s3;
	fpa_pkg::fpa_side_t side_s3;
	fpa_pkg::fpa_div_t  div_s3;
	logic               div_valid;
	fpa_pkg::fpa_side_t div_side;
	fpa_pkg::fpa_div_t  div_out;
	logic               valid_q;
	logic [31:0]        res_q;
	logic               cmp_q;
	logic [1:0]         status_q;

	assign en        = !valid_q || rsp.ready;
	assign req.ready = en;

	fpa_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (req.valid),
		.op       (req.req_type),
		.a        (req.operand_a),
		.b        (req.operand_b),
		.valid_s3 (valid_s3),
		.side_s3  (side_s3),
		.div_s3   (div_s3)
	);

	fpa_div_pipe u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (valid_s3),
		.in_side   (side_s3),
		.in_div    (div_s3),
		.out_valid (div_valid),
		.out_side  (div_side),
		.out_div   (div_out)
	);

	fpa_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (div_valid),
		.in_side  (div_side),
		.in_div   (div_out),
		.valid_q  (valid_q),
		.res_q    (res_q),
		.cmp_q    (cmp_q),
		.status_q (status_q)
	);

	assign rsp.valid        = valid_q;
	assign rsp.result_value = res_q;
	assign rsp.compare_true = cmp_q;
	assign rsp.status       = status_q;

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> rsp.status <= fpa_pkg::STAT_DIV0)
		else $error("reserved status code");

	a_cmp_clean: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.compare_true |-> rsp.result_value == '0 && rsp.status == fpa_pkg::STAT_OK)
		else $error("comparison beat carries a value or status");

	a_div0_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.status == fpa_pkg::STAT_DIV0 |-> rsp.result_value == '0)
		else $error("divide by zero beat not zero");

	a_stall_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		!en |-> !req.ready)
		else $error("request taken during stall");

endmodule
`default_nettype wire
